@@ design/gemb_pkg.sv @@
package gemb_pkg;

   // Field and datapath widths
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned REL_W    = WORD_W + 1;            // exact difference of two words
   localparam int unsigned SQ_W     = 2 * REL_W;             // squared distance, Q.56
   localparam int unsigned ROOT_W   = REL_W;                 // integer square root, Q.28
   localparam int unsigned HALF_W   = SQ_W / 2;              // split of d2 for the d3 product
   localparam int unsigned K_W      = 2 * WORD_W;            // gm * dt, Q.56
   localparam int unsigned KP_W     = WORD_W + REL_W;        // partial product of k and |rel|
   localparam int unsigned KM_W     = K_W + REL_W;           // k * |rel|
   localparam int unsigned FRAC_W   = 28;
   localparam int unsigned NUM_W    = KM_W + FRAC_W;         // division numerator
   localparam int unsigned D3_W     = SQ_W + ROOT_W;         // d2 * r, Q.84
   localparam int unsigned Q_BITS   = 41;                    // quotient bits 40..0
   localparam int unsigned CMP_W    = D3_W + Q_BITS;         // divisor shifted by the top bit
   localparam int unsigned PULL_W   = Q_BITS + 1;            // signed pull component
   localparam int unsigned ACC_W    = PULL_W + 1;            // sum of two pulls
   localparam int unsigned SUM_W    = 44;                    // velocity / position sums
   localparam int unsigned PMUL_W   = 2 * WORD_W;

   // Pipeline depths
   localparam int unsigned PULL_LAT = 4 + ROOT_W + 3 + Q_BITS + 1;
   localparam int unsigned BACK_LAT = PULL_LAT + 4;
   localparam int unsigned PEND_W   = $clog2(BACK_LAT + 2);

   // Command queue between front and back
   localparam int unsigned CQ_DEPTH = 4;
   localparam int unsigned CQ_AW    = $clog2(CQ_DEPTH);

   // Request codes
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_ADV  = 2'd1;
   localparam logic [1:0] REQ_TEST = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_SUN_MASS    = 2'd0;
   localparam logic [1:0] CSR_PLANET_MASS = 2'd1;
   localparam logic [1:0] CSR_TIME_STEP   = 2'd2;

   // Reset values
   localparam logic [WORD_W-1:0] SUN_MASS_RST    = 32'd268435456;
   localparam logic [WORD_W-1:0] PLANET_MASS_RST = 32'd256088;
   localparam logic [WORD_W-1:0] TIME_STEP_RST   = 32'd2684355;
   localparam logic [WORD_W-1:0] PLANET_X_RST    = 32'd268435456;
   localparam logic [WORD_W-1:0] PLANET_Y_RST    = 32'd0;
   localparam logic [WORD_W-1:0] PLANET_VX_RST   = 32'd0;
   localparam logic [WORD_W-1:0] PLANET_VY_RST   = 32'd268435456;

   typedef enum logic [1:0] {
      KIND_LOAD = 2'd0,
      KIND_ADV  = 2'd1,
      KIND_TEST = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [WORD_W-1:0] pos_x;
      logic [WORD_W-1:0] pos_y;
      logic [WORD_W-1:0] vel_x;
      logic [WORD_W-1:0] vel_y;
   } cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0] sun_mass;
      logic [WORD_W-1:0] planet_mass;
      logic [WORD_W-1:0] time_step;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic [WORD_W-1:0] new_pos_x;
      logic [WORD_W-1:0] new_pos_y;
      logic [WORD_W-1:0] new_vel_x;
      logic [WORD_W-1:0] new_vel_y;
      logic              singular;
      logic              saturated;
   } res_type;

   // Magnitude of a two's complement relative coordinate
   function automatic logic [REL_W-1:0] mag_rel(input logic [REL_W-1:0] v);
      return v[REL_W-1] ? (~v + REL_W'(1)) : v;
   endfunction

   // Clip a wide sum to a signed word; top bit of the result flags a clip
   function automatic logic [WORD_W:0] sat_word(input logic [SUM_W-1:0] v);
      logic all_same;
      all_same = (v[SUM_W-1:WORD_W-1] == '0) || (v[SUM_W-1:WORD_W-1] == '1);
      if (all_same) begin
         return {1'b0, v[WORD_W-1:0]};
      end else if (v[SUM_W-1]) begin
         return {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

endpackage

@@ design/gemb_front.sv @@
module gemb_front import gemb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_type,
   input  logic [WORD_W-1:0] req_pos_x,
   input  logic [WORD_W-1:0] req_pos_y,
   input  logic [WORD_W-1:0] req_vel_x,
   input  logic [WORD_W-1:0] req_vel_y,
   input  logic              cq_full,
   output logic              cmd_valid,
   output cmd_type           cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    keep;
   logic    accept;

   assign req_full  = valid_ff && cq_full;
   assign accept    = req_push && !req_full;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   // Classify the request; drop the unused code
   always_comb begin
      keep         = 1'b1;
      cmd_in       = cmd_ff;
      cmd_in.pos_x = req_pos_x;
      cmd_in.pos_y = req_pos_y;
      cmd_in.vel_x = req_vel_x;
      cmd_in.vel_y = req_vel_y;
      case (req_type)
         REQ_LOAD: cmd_in.kind = KIND_LOAD;
         REQ_ADV:  cmd_in.kind = KIND_ADV;
         REQ_TEST: cmd_in.kind = KIND_TEST;
         default:  keep = 1'b0;
      endcase
   end

   // Hold the slot until the queue takes it
   always_comb begin
      if (accept) begin
         valid_in = keep;
      end else begin
         valid_in = valid_ff && cq_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

@@ design/gemb_fifo.sv @@
module gemb_fifo import gemb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head
);

   cmd_type          entry_ff [CQ_DEPTH];
   logic [CQ_AW-1:0] rd_ptr_ff, wr_ptr_ff;
   logic [CQ_AW:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == (CQ_AW+1)'(CQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (CQ_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (CQ_AW+1)'(1);
      end
   end

   // Advance pointers and hold the count
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + CQ_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + CQ_AW'(1);
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ design/gemb_pull.sv @@
module gemb_pull import gemb_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  logic [WORD_W-1:0] gm,
   input  logic [WORD_W-1:0] dt,
   input  logic [REL_W-1:0]  rel_x,
   input  logic [REL_W-1:0]  rel_y,
   input  logic              en,
   output logic [PULL_W-1:0] pull_x,
   output logic [PULL_W-1:0] pull_y,
   output logic              sing,
   output logic              clip
);

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic zero;
      logic en;
   } flag_type;

   // Stage 1: magnitudes and flags
   logic [REL_W-1:0]  mx_s1_ff, my_s1_ff;
   logic [WORD_W-1:0] gm_s1_ff;
   flag_type          fl_s1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_s1_ff       <= mag_rel(rel_x);
         my_s1_ff       <= mag_rel(rel_y);
         gm_s1_ff       <= gm;
         fl_s1_ff.neg_x <= rel_x[REL_W-1];
         fl_s1_ff.neg_y <= rel_y[REL_W-1];
         fl_s1_ff.zero  <= (rel_x == '0) && (rel_y == '0);
         fl_s1_ff.en    <= en;
      end
   end

   // Stage 2: squares and gm * dt
   logic [SQ_W-1:0]  sqx_s2_ff, sqy_s2_ff;
   logic [K_W-1:0]   k_s2_ff;
   logic [REL_W-1:0] mx_s2_ff, my_s2_ff;
   flag_type         fl_s2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_s2_ff <= SQ_W'(mx_s1_ff) * SQ_W'(mx_s1_ff);
         sqy_s2_ff <= SQ_W'(my_s1_ff) * SQ_W'(my_s1_ff);
         k_s2_ff   <= K_W'(gm_s1_ff) * K_W'(dt);
         mx_s2_ff  <= mx_s1_ff;
         my_s2_ff  <= my_s1_ff;
         fl_s2_ff  <= fl_s1_ff;
      end
   end

   // Stage 3: d2 and partial products of k * |rel|
   logic [SQ_W-1:0] d2_s3_ff;
   logic [KP_W-1:0] kx_lo_s3_ff, kx_hi_s3_ff, ky_lo_s3_ff, ky_hi_s3_ff;
   flag_type        fl_s3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_s3_ff    <= sqx_s2_ff + sqy_s2_ff;
         kx_lo_s3_ff <= KP_W'(k_s2_ff[WORD_W-1:0]) * KP_W'(mx_s2_ff);
         kx_hi_s3_ff <= KP_W'(k_s2_ff[K_W-1:WORD_W]) * KP_W'(mx_s2_ff);
         ky_lo_s3_ff <= KP_W'(k_s2_ff[WORD_W-1:0]) * KP_W'(my_s2_ff);
         ky_hi_s3_ff <= KP_W'(k_s2_ff[K_W-1:WORD_W]) * KP_W'(my_s2_ff);
         fl_s3_ff    <= fl_s2_ff;
      end
   end

   // Stage 4: sum partial products
   logic [SQ_W-1:0] d2_s4_ff;
   logic [KM_W-1:0] kmx_s4_ff, kmy_s4_ff;
   flag_type        fl_s4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_s4_ff  <= d2_s3_ff;
         kmx_s4_ff <= KM_W'(kx_lo_s3_ff) + {kx_hi_s3_ff, {WORD_W{1'b0}}};
         kmy_s4_ff <= KM_W'(ky_lo_s3_ff) + {ky_hi_s3_ff, {WORD_W{1'b0}}};
         fl_s4_ff  <= fl_s3_ff;
      end
   end

   // Square root, one result bit per stage
   logic [ROOT_W-1:0] sq_root_ff [ROOT_W];
   logic [SQ_W-1:0]   sq_rem_ff  [ROOT_W];
   logic [SQ_W-1:0]   sq_d2_ff   [ROOT_W];
   logic [KM_W-1:0]   sq_kmx_ff  [ROOT_W];
   logic [KM_W-1:0]   sq_kmy_ff  [ROOT_W];
   flag_type          sq_fl_ff   [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      localparam int unsigned B = ROOT_W - 1 - j;
      logic [ROOT_W-1:0] root_p;
      logic [SQ_W-1:0]   rem_p, d2_p;
      logic [KM_W-1:0]   kmx_p, kmy_p;
      flag_type          fl_p;
      logic [SQ_W+1:0]   trial;
      logic              take;

      if (j == 0) begin : g_first
         assign root_p = '0;
         assign rem_p  = d2_s4_ff;
         assign d2_p   = d2_s4_ff;
         assign kmx_p  = kmx_s4_ff;
         assign kmy_p  = kmy_s4_ff;
         assign fl_p   = fl_s4_ff;
      end else begin : g_next
         assign root_p = sq_root_ff[j-1];
         assign rem_p  = sq_rem_ff[j-1];
         assign d2_p   = sq_d2_ff[j-1];
         assign kmx_p  = sq_kmx_ff[j-1];
         assign kmy_p  = sq_kmy_ff[j-1];
         assign fl_p   = sq_fl_ff[j-1];
      end

      // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
      assign trial = ((SQ_W+2)'(root_p) << (B + 1)) + ((SQ_W+2)'(1) << (2 * B));
      assign take  = (SQ_W+2)'(rem_p) >= trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[j]  <= take ? (rem_p - trial[SQ_W-1:0]) : rem_p;
            sq_root_ff[j] <= take ? (root_p | (ROOT_W'(1) << B)) : root_p;
            sq_d2_ff[j]   <= d2_p;
            sq_kmx_ff[j]  <= kmx_p;
            sq_kmy_ff[j]  <= kmy_p;
            sq_fl_ff[j]   <= fl_p;
         end
      end
   end

   // d3 = d2 * r in two halves, then the sum
   logic [SQ_W-1:0] pa_ff, pb_ff;
   logic [KM_W-1:0] kmx_m_ff, kmy_m_ff;
   flag_type        fl_m_ff;
   logic [D3_W-1:0] d3_ff;
   logic [NUM_W-1:0] nx_ff, ny_ff;
   flag_type        fl_n_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff    <= SQ_W'(sq_d2_ff[ROOT_W-1][HALF_W-1:0]) * SQ_W'(sq_root_ff[ROOT_W-1]);
         pb_ff    <= SQ_W'(sq_d2_ff[ROOT_W-1][SQ_W-1:HALF_W]) * SQ_W'(sq_root_ff[ROOT_W-1]);
         kmx_m_ff <= sq_kmx_ff[ROOT_W-1];
         kmy_m_ff <= sq_kmy_ff[ROOT_W-1];
         fl_m_ff  <= sq_fl_ff[ROOT_W-1];
         d3_ff    <= D3_W'(pa_ff) + {pb_ff, {HALF_W{1'b0}}};
         nx_ff    <= {kmx_m_ff, {FRAC_W{1'b0}}};
         ny_ff    <= {kmy_m_ff, {FRAC_W{1'b0}}};
         fl_n_ff  <= fl_m_ff;
      end
   end

   // Quotient overflow check above the top quotient bit
   logic [D3_W-1:0]  d3_o_ff;
   logic [NUM_W-1:0] nx_o_ff, ny_o_ff;
   logic             ovfx_o_ff, ovfy_o_ff;
   flag_type         fl_o_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         d3_o_ff   <= d3_ff;
         nx_o_ff   <= nx_ff;
         ny_o_ff   <= ny_ff;
         ovfx_o_ff <= CMP_W'(nx_ff) >= {d3_ff, {Q_BITS{1'b0}}};
         ovfy_o_ff <= CMP_W'(ny_ff) >= {d3_ff, {Q_BITS{1'b0}}};
         fl_o_ff   <= fl_n_ff;
      end
   end

   // Restoring division, one quotient bit per stage, both axes together
   logic [NUM_W-1:0]  dv_remx_ff [Q_BITS];
   logic [NUM_W-1:0]  dv_remy_ff [Q_BITS];
   logic [Q_BITS-1:0] dv_qx_ff   [Q_BITS];
   logic [Q_BITS-1:0] dv_qy_ff   [Q_BITS];
   logic [D3_W-1:0]   dv_d3_ff   [Q_BITS];
   logic              dv_ovfx_ff [Q_BITS];
   logic              dv_ovfy_ff [Q_BITS];
   flag_type          dv_fl_ff   [Q_BITS];

   for (genvar j = 0; j < Q_BITS; j++) begin : g_div
      localparam int unsigned B = Q_BITS - 1 - j;
      logic [NUM_W-1:0]  remx_p, remy_p;
      logic [Q_BITS-1:0] qx_p, qy_p;
      logic [D3_W-1:0]   d3_p;
      logic              ovfx_p, ovfy_p;
      flag_type          fl_p;
      logic [CMP_W-1:0]  dsh, diffx, diffy;
      logic              takex, takey;

      if (j == 0) begin : g_first
         assign remx_p = nx_o_ff;
         assign remy_p = ny_o_ff;
         assign qx_p   = '0;
         assign qy_p   = '0;
         assign d3_p   = d3_o_ff;
         assign ovfx_p = ovfx_o_ff;
         assign ovfy_p = ovfy_o_ff;
         assign fl_p   = fl_o_ff;
      end else begin : g_next
         assign remx_p = dv_remx_ff[j-1];
         assign remy_p = dv_remy_ff[j-1];
         assign qx_p   = dv_qx_ff[j-1];
         assign qy_p   = dv_qy_ff[j-1];
         assign d3_p   = dv_d3_ff[j-1];
         assign ovfx_p = dv_ovfx_ff[j-1];
         assign ovfy_p = dv_ovfy_ff[j-1];
         assign fl_p   = dv_fl_ff[j-1];
      end

      assign dsh   = CMP_W'(d3_p) << B;
      assign takex = CMP_W'(remx_p) >= dsh;
      assign takey = CMP_W'(remy_p) >= dsh;
      assign diffx = CMP_W'(remx_p) - dsh;
      assign diffy = CMP_W'(remy_p) - dsh;

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_remx_ff[j] <= takex ? diffx[NUM_W-1:0] : remx_p;
            dv_remy_ff[j] <= takey ? diffy[NUM_W-1:0] : remy_p;
            dv_qx_ff[j]   <= takex ? (qx_p | (Q_BITS'(1) << B)) : qx_p;
            dv_qy_ff[j]   <= takey ? (qy_p | (Q_BITS'(1) << B)) : qy_p;
            dv_d3_ff[j]   <= d3_p;
            dv_ovfx_ff[j] <= ovfx_p;
            dv_ovfy_ff[j] <= ovfy_p;
            dv_fl_ff[j]   <= fl_p;
         end
      end
   end

   // Clamp, apply sign, drop skipped pulls
   localparam logic [Q_BITS-1:0] PULL_CAP = Q_BITS'(1) << (Q_BITS - 1);

   logic [Q_BITS-1:0] qx_f, qy_f, magx, magy;
   logic              capx, capy, live;
   flag_type          fl_f;
   logic [PULL_W-1:0] extx, exty;
   logic [PULL_W-1:0] pull_x_ff, pull_y_ff;
   logic              sing_ff, clip_ff;

   assign qx_f = dv_qx_ff[Q_BITS-1];
   assign qy_f = dv_qy_ff[Q_BITS-1];
   assign fl_f = dv_fl_ff[Q_BITS-1];
   assign capx = dv_ovfx_ff[Q_BITS-1] || (qx_f > PULL_CAP);
   assign capy = dv_ovfy_ff[Q_BITS-1] || (qy_f > PULL_CAP);
   assign magx = capx ? PULL_CAP : qx_f;
   assign magy = capy ? PULL_CAP : qy_f;
   assign live = fl_f.en && !fl_f.zero;
   assign extx = live ? {1'b0, magx} : '0;
   assign exty = live ? {1'b0, magy} : '0;

   always_ff @(posedge clock) begin
      if (adv) begin
         pull_x_ff <= fl_f.neg_x ? (~extx + PULL_W'(1)) : extx;
         pull_y_ff <= fl_f.neg_y ? (~exty + PULL_W'(1)) : exty;
         sing_ff   <= fl_f.en && fl_f.zero;
         clip_ff   <= live && (capx || capy);
      end
   end

   assign pull_x = pull_x_ff;
   assign pull_y = pull_y_ff;
   assign sing   = sing_ff;
   assign clip   = clip_ff;

endmodule

@@ design/gemb_back.sv @@
module gemb_back import gemb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    head_valid,
   input  cmd_type head,
   output logic    head_pop,
   input  logic    room,
   output logic    res_valid,
   output res_type res
);

   logic adv, issue, retire;

   // Planet state, written back in order at retirement
   logic [WORD_W-1:0] planet_x_ff, planet_y_ff, planet_vx_ff, planet_vy_ff;
   logic [PEND_W-1:0] pend_ff, pend_in;

   assign adv      = room;
   assign issue    = head_valid && adv && ((head.kind == KIND_LOAD) || (pend_ff == '0));
   assign head_pop = issue;

   // Pick the receiver and form the relative vectors
   cmd_type          rcv;
   logic [REL_W-1:0] px_e, py_e, sun_rx, sun_ry, pl_rx, pl_ry;

   always_comb begin
      rcv = head;
      if (head.kind == KIND_ADV) begin
         rcv.pos_x = planet_x_ff;
         rcv.pos_y = planet_y_ff;
         rcv.vel_x = planet_vx_ff;
         rcv.vel_y = planet_vy_ff;
      end
   end

   assign px_e   = {rcv.pos_x[WORD_W-1], rcv.pos_x};
   assign py_e   = {rcv.pos_y[WORD_W-1], rcv.pos_y};
   assign sun_rx = REL_W'(0) - px_e;
   assign sun_ry = REL_W'(0) - py_e;
   assign pl_rx  = {planet_x_ff[WORD_W-1], planet_x_ff} - px_e;
   assign pl_ry  = {planet_y_ff[WORD_W-1], planet_y_ff} - py_e;

   logic [PULL_W-1:0] ps_x, ps_y, pp_x, pp_y;
   logic              ps_sing, ps_clip, pp_sing, pp_clip;

   gemb_pull u_sun (
      .clock  (clock),
      .adv    (adv),
      .gm     (cfg.sun_mass),
      .dt     (cfg.time_step),
      .rel_x  (sun_rx),
      .rel_y  (sun_ry),
      .en     (rcv.kind != KIND_LOAD),
      .pull_x (ps_x),
      .pull_y (ps_y),
      .sing   (ps_sing),
      .clip   (ps_clip)
   );

   gemb_pull u_planet (
      .clock  (clock),
      .adv    (adv),
      .gm     (cfg.planet_mass),
      .dt     (cfg.time_step),
      .rel_x  (pl_rx),
      .rel_y  (pl_ry),
      .en     (rcv.kind == KIND_TEST),
      .pull_x (pp_x),
      .pull_y (pp_y),
      .sing   (pp_sing),
      .clip   (pp_clip)
   );

   // Carry the item alongside the pull pipelines
   logic    pl_valid_ff [PULL_LAT];
   cmd_type pl_cmd_ff   [PULL_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PULL_LAT; i++) begin
            pl_valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         pl_valid_ff[0] <= issue;
         for (int i = 1; i < PULL_LAT; i++) begin
            pl_valid_ff[i] <= pl_valid_ff[i-1];
         end
      end
      if (adv) begin
         pl_cmd_ff[0] <= rcv;
         for (int i = 1; i < PULL_LAT; i++) begin
            pl_cmd_ff[i] <= pl_cmd_ff[i-1];
         end
      end
   end

   // Stage A: sum the two pulls
   logic             a_valid_ff;
   cmd_type          a_cmd_ff;
   logic [ACC_W-1:0] ax_a_ff, ay_a_ff;
   logic             a_sing_ff, a_clip_ff;

   // Stage B: new velocity
   logic              b_valid_ff;
   cmd_type           b_cmd_ff;
   logic [WORD_W-1:0] vx_b_ff, vy_b_ff;
   logic              b_sing_ff, b_clip_ff;
   logic [WORD_W:0]   satx_b, saty_b;

   // Stage C: velocity times dt
   logic              c_valid_ff;
   cmd_type           c_cmd_ff;
   logic [WORD_W-1:0] vx_c_ff, vy_c_ff;
   logic [PMUL_W-1:0] mvx_c_ff, mvy_c_ff;
   logic              c_sing_ff, c_clip_ff;
   logic [WORD_W-1:0] absvx_b, absvy_b;

   // Stage D: new position and result
   logic              d_valid_ff;
   res_type           d_res_ff, d_res_in;
   logic [SUM_W-1:0]  dpx, dpy;
   logic [WORD_W:0]   satpx, satpy;

   assign satx_b  = sat_word({{(SUM_W-WORD_W){a_cmd_ff.vel_x[WORD_W-1]}}, a_cmd_ff.vel_x}
                             + {{(SUM_W-ACC_W){ax_a_ff[ACC_W-1]}}, ax_a_ff});
   assign saty_b  = sat_word({{(SUM_W-WORD_W){a_cmd_ff.vel_y[WORD_W-1]}}, a_cmd_ff.vel_y}
                             + {{(SUM_W-ACC_W){ay_a_ff[ACC_W-1]}}, ay_a_ff});
   assign absvx_b = vx_b_ff[WORD_W-1] ? (~vx_b_ff + WORD_W'(1)) : vx_b_ff;
   assign absvy_b = vy_b_ff[WORD_W-1] ? (~vy_b_ff + WORD_W'(1)) : vy_b_ff;

   always_comb begin
      dpx = SUM_W'(mvx_c_ff[PMUL_W-1:FRAC_W]);
      dpy = SUM_W'(mvy_c_ff[PMUL_W-1:FRAC_W]);
      if (vx_c_ff[WORD_W-1]) begin
         dpx = ~dpx + SUM_W'(1);
      end
      if (vy_c_ff[WORD_W-1]) begin
         dpy = ~dpy + SUM_W'(1);
      end
      satpx = sat_word({{(SUM_W-WORD_W){c_cmd_ff.pos_x[WORD_W-1]}}, c_cmd_ff.pos_x} + dpx);
      satpy = sat_word({{(SUM_W-WORD_W){c_cmd_ff.pos_y[WORD_W-1]}}, c_cmd_ff.pos_y} + dpy);

      d_res_in.kind = c_cmd_ff.kind;
      if (c_cmd_ff.kind == KIND_LOAD) begin
         d_res_in.new_pos_x = c_cmd_ff.pos_x;
         d_res_in.new_pos_y = c_cmd_ff.pos_y;
         d_res_in.new_vel_x = c_cmd_ff.vel_x;
         d_res_in.new_vel_y = c_cmd_ff.vel_y;
         d_res_in.singular  = 1'b0;
         d_res_in.saturated = 1'b0;
      end else begin
         d_res_in.new_pos_x = satpx[WORD_W-1:0];
         d_res_in.new_pos_y = satpy[WORD_W-1:0];
         d_res_in.new_vel_x = vx_c_ff;
         d_res_in.new_vel_y = vy_c_ff;
         d_res_in.singular  = c_sing_ff;
         d_res_in.saturated = c_clip_ff || satpx[WORD_W] || satpy[WORD_W];
      end
   end

   // Advance the tail stages together
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= pl_valid_ff[PULL_LAT-1];
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
      if (adv) begin
         a_cmd_ff  <= pl_cmd_ff[PULL_LAT-1];
         ax_a_ff   <= {ps_x[PULL_W-1], ps_x} + {pp_x[PULL_W-1], pp_x};
         ay_a_ff   <= {ps_y[PULL_W-1], ps_y} + {pp_y[PULL_W-1], pp_y};
         a_sing_ff <= ps_sing || pp_sing;
         a_clip_ff <= ps_clip || pp_clip;

         b_cmd_ff  <= a_cmd_ff;
         vx_b_ff   <= satx_b[WORD_W-1:0];
         vy_b_ff   <= saty_b[WORD_W-1:0];
         b_sing_ff <= a_sing_ff;
         b_clip_ff <= a_clip_ff || satx_b[WORD_W] || saty_b[WORD_W];

         c_cmd_ff  <= b_cmd_ff;
         vx_c_ff   <= vx_b_ff;
         vy_c_ff   <= vy_b_ff;
         mvx_c_ff  <= PMUL_W'(absvx_b) * PMUL_W'(cfg.time_step);
         mvy_c_ff  <= PMUL_W'(absvy_b) * PMUL_W'(cfg.time_step);
         c_sing_ff <= b_sing_ff;
         c_clip_ff <= b_clip_ff;

         d_res_ff  <= d_res_in;
      end
   end

   assign res_valid = d_valid_ff;
   assign res       = d_res_ff;
   assign retire    = d_valid_ff && adv;

   // Count planet writers in flight
   always_comb begin
      pend_in = pend_ff;
      if (issue && (head.kind != KIND_TEST)) begin
         pend_in = pend_in + PEND_W'(1);
      end
      if (retire && (d_res_ff.kind != KIND_TEST)) begin
         pend_in = pend_in - PEND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         planet_x_ff  <= PLANET_X_RST;
         planet_y_ff  <= PLANET_Y_RST;
         planet_vx_ff <= PLANET_VX_RST;
         planet_vy_ff <= PLANET_VY_RST;
      end else begin
         pend_ff <= pend_in;
         if (retire && (d_res_ff.kind != KIND_TEST)) begin
            planet_x_ff  <= d_res_ff.new_pos_x;
            planet_y_ff  <= d_res_ff.new_pos_y;
            planet_vx_ff <= d_res_ff.new_vel_x;
            planet_vy_ff <= d_res_ff.new_vel_y;
         end
      end
   end

endmodule

@@ design/gravity_euler_body_step_unit.sv @@
// Semi-implicit Euler gravity step: sun fixed at the origin, one stored planet,
// signed Q4.28 state.
// Request side: push/full queue. An item is taken when push is high and full
// is low; req_type selects load planet, advance planet or advance test body.
// Code 3 is taken and dropped without a result.
// Result side: empty/pop queue. The oldest result stands on the rsp_ ports
// while empty is low and leaves on pop.
// Registers: csr_valid/csr_ready write port, always ready; write it only when
// the block is idle.
// Each pull pipeline holds a square root of 33 stages, one result bit per
// stage, and a restoring divider of 41 stages. Test bodies stream at one item
// per cycle while the result queue has room. A test body or advance item that
// follows a load or advance waits until that item has written the planet back.
// Reset restores the register defaults and the initial planet, empties both
// queues and the pipeline. When the receiver stops popping, the pipeline freezes,
// the command queue stops draining and full rises once it and the front slot fill.
module gravity_euler_body_step_unit import gemb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_type,
   input  logic [WORD_W-1:0] req_pos_x,
   input  logic [WORD_W-1:0] req_pos_y,
   input  logic [WORD_W-1:0] req_vel_x,
   input  logic [WORD_W-1:0] req_vel_y,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [WORD_W-1:0] rsp_new_pos_x,
   output logic [WORD_W-1:0] rsp_new_pos_y,
   output logic [WORD_W-1:0] rsp_new_vel_x,
   output logic [WORD_W-1:0] rsp_new_vel_y,
   output logic              rsp_singular,
   output logic              rsp_saturated,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [WORD_W-1:0] csr_data
);

   // Configuration registers
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sun_mass    <= SUN_MASS_RST;
         cfg_ff.planet_mass <= PLANET_MASS_RST;
         cfg_ff.time_step   <= TIME_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SUN_MASS:    cfg_ff.sun_mass    <= csr_data;
            CSR_PLANET_MASS: cfg_ff.planet_mass <= csr_data;
            CSR_TIME_STEP:   cfg_ff.time_step   <= csr_data;
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   // Front, command queue, back
   logic    f_valid, cq_full, cq_push, head_valid, head_pop;
   cmd_type f_cmd, head;
   logic    room, res_valid;
   res_type res;

   gemb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_type  (req_type),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .req_vel_x (req_vel_x),
      .req_vel_y (req_vel_y),
      .cq_full   (cq_full),
      .cmd_valid (f_valid),
      .cmd       (f_cmd)
   );

   assign cq_push = f_valid && !cq_full;

   gemb_fifo u_cq (
      .clock      (clock),
      .reset      (reset),
      .push       (cq_push),
      .push_cmd   (f_cmd),
      .full       (cq_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   gemb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .room       (room),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Two-entry result queue
   res_type    oq_ff [2];
   logic       oq_rd_ff;
   logic [1:0] oq_count_ff, oq_count_in;
   logic       oq_push, oq_pop;
   logic       oq_wr;
   res_type    oq_head;

   assign room      = (oq_count_ff != 2'd2);
   assign oq_push   = res_valid && room;
   assign rsp_empty = (oq_count_ff == 2'd0);
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign oq_wr     = oq_rd_ff ^ oq_count_ff[0];
   assign oq_head   = oq_ff[oq_rd_ff];

   always_comb begin
      oq_count_in = oq_count_ff;
      if (oq_push && !oq_pop) begin
         oq_count_in = oq_count_ff + 2'd1;
      end else if (oq_pop && !oq_push) begin
         oq_count_in = oq_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_rd_ff    <= 1'b0;
         oq_count_ff <= 2'd0;
      end else begin
         oq_count_ff <= oq_count_in;
         if (oq_pop) begin
            oq_rd_ff <= !oq_rd_ff;
         end
      end
      if (oq_push) begin
         oq_ff[oq_wr] <= res;
      end
   end

   assign rsp_new_pos_x = oq_head.new_pos_x;
   assign rsp_new_pos_y = oq_head.new_pos_y;
   assign rsp_new_vel_x = oq_head.new_vel_x;
   assign rsp_new_vel_y = oq_head.new_vel_y;
   assign rsp_singular  = oq_head.singular;
   assign rsp_saturated = oq_head.saturated;

   // Result queue never holds more than two items
   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oq_count_ff != 2'd3)
      else $error("result queue count out of range");

   // A load echoes its item without flags
   a_load_clean: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.kind == KIND_LOAD)) |-> (!res.singular && !res.saturated))
      else $error("load result carries flags");

   // Popping the last result with nothing arriving empties the queue
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (oq_pop && !oq_push && (oq_count_ff == 2'd1)) |=> rsp_empty)
      else $error("result queue failed to drain");

endmodule

@@ verif/gravity_euler_body_step_unit_tb.sv @@
module gravity_euler_body_step_unit_tb;
   import gemb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REQ_NONE = 2'd3;   // unused code, dropped by the block
   localparam int DRAIN_CYCLES = 120;        // a little over the pipeline latency

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] px, py, vx, vy;
   } body_item_type;

   typedef struct {
      logic [31:0] px, py, vx, vy;
      logic        sing, sat;
   } step_result_type;

   // Step predictor and queue of expected bodies
   class body_scoreboard_type;
      logic [31:0]     sun_gm, planet_gm, dt;
      longint          plx, ply, plvx, plvy;
      step_result_type expected_steps[$];

      function new();
         sun_gm = SUN_MASS_RST;
         planet_gm = PLANET_MASS_RST;
         dt = TIME_STEP_RST;
         plx = 268435456;
         ply = 0;
         plvx = 0;
         plvy = 268435456;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_SUN_MASS:    sun_gm = val;
            CSR_PLANET_MASS: planet_gm = val;
            CSR_TIME_STEP:   dt = val;
            default: ;
         endcase
      endfunction

      function longint clip32(longint v, inout bit sat);
         if (v > 64'sd2147483647) begin
            sat = 1;
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            sat = 1;
            return -64'sd2147483648;
         end
         return v;
      endfunction

      // Pull of gm along (rx, ry); returns 1 on a zero distance
      function bit add_pull(logic [31:0] gm, longint rx, longint ry,
                            inout longint ax, inout longint ay, inout bit sat);
         logic [255:0] mx, my, d2, r, c, d3, k, qx, qy, cap;
         mx = rx < 0 ? -rx : rx;
         my = ry < 0 ? -ry : ry;
         if (mx == 0 && my == 0) return 1;
         d2 = mx * mx + my * my;
         r = 0;
         for (int b = 33; b >= 0; b--) begin
            c = r | (256'd1 << b);
            if (c * c <= d2) r = c;
         end
         d3 = d2 * r;
         k = 256'(gm) * 256'(dt);
         cap = 256'd1 << 40;
         qx = ((k * mx) << 28) / d3;
         qy = ((k * my) << 28) / d3;
         if (qx > cap) begin
            qx = cap;
            sat = 1;
         end
         if (qy > cap) begin
            qy = cap;
            sat = 1;
         end
         ax += rx < 0 ? -longint'(qx[63:0]) : longint'(qx[63:0]);
         ay += ry < 0 ? -longint'(qy[63:0]) : longint'(qy[63:0]);
         return 0;
      endfunction

      function longint drift(longint p, longint v, inout bit sat);
         logic [63:0] d;
         d = (64'(v < 0 ? -v : v) * 64'(dt)) >> 28;
         return clip32(p + (v < 0 ? -longint'(d) : longint'(d)), sat);
      endfunction

      // Work out the result of an accepted item
      function void note_item(body_item_type it);
         longint px, py, vx, vy, ax, ay;
         bit sing, sat;
         step_result_type res;
         if (it.kind == REQ_NONE) return;
         px = longint'(signed'(it.px));
         py = longint'(signed'(it.py));
         vx = longint'(signed'(it.vx));
         vy = longint'(signed'(it.vy));
         sing = 0;
         sat = 0;
         if (it.kind == REQ_LOAD) begin
            plx = px; ply = py; plvx = vx; plvy = vy;
         end else begin
            ax = 0;
            ay = 0;
            if (it.kind == REQ_ADV) begin
               px = plx; py = ply; vx = plvx; vy = plvy;
            end
            sing |= add_pull(sun_gm, -px, -py, ax, ay, sat);
            if (it.kind == REQ_TEST)
               sing |= add_pull(planet_gm, plx - px, ply - py, ax, ay, sat);
            vx = clip32(vx + ax, sat);
            vy = clip32(vy + ay, sat);
            px = drift(px, vx, sat);
            py = drift(py, vy, sat);
            if (it.kind == REQ_ADV) begin
               plx = px; ply = py; plvx = vx; plvy = vy;
            end
         end
         res.px = px[31:0];
         res.py = py[31:0];
         res.vx = vx[31:0];
         res.vy = vy[31:0];
         res.sing = sing;
         res.sat = sat;
         expected_steps.push_back(res);
      endfunction

      // Compare a result with the oldest expectation
      function bit check_result(step_result_type got, output string msg);
         step_result_type e;
         msg = "";
         if (expected_steps.size() == 0) begin
            msg = "result with no item pending";
            return 0;
         end
         e = expected_steps.pop_front();
         if (got.px !== e.px) msg = {msg, $sformatf(" pos_x %h/%h", got.px, e.px)};
         if (got.py !== e.py) msg = {msg, $sformatf(" pos_y %h/%h", got.py, e.py)};
         if (got.vx !== e.vx) msg = {msg, $sformatf(" vel_x %h/%h", got.vx, e.vx)};
         if (got.vy !== e.vy) msg = {msg, $sformatf(" vel_y %h/%h", got.vy, e.vy)};
         if (got.sing !== e.sing) msg = {msg, $sformatf(" singular %b/%b", got.sing, e.sing)};
         if (got.sat !== e.sat) msg = {msg, $sformatf(" saturated %b/%b", got.sat, e.sat)};
         return msg == "";
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [1:0]  req_type = REQ_LOAD;
   logic [31:0] req_pos_x = 0, req_pos_y = 0, req_vel_x = 0, req_vel_y = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [31:0] rsp_new_pos_x, rsp_new_pos_y, rsp_new_vel_x, rsp_new_vel_y;
   logic        rsp_singular, rsp_saturated;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_SUN_MASS;
   logic [31:0] csr_data = 0;

   body_scoreboard_type sb = new();
   int  error_count = 0;
   bit  idling_on = 1;
   bit  hold_request = 0;

   gravity_euler_body_step_unit DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   task automatic report(string msg);
      $display("mismatch at %0t:%s", $realtime, msg);
      error_count++;
   endtask

   // Pop results with random bursts of idling and an occasional long hold
   initial begin
      int hold_left, gap_left;
      step_result_type got;
      string msg;
      hold_left = 0;
      gap_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            got.px = rsp_new_pos_x;
            got.py = rsp_new_pos_y;
            got.vx = rsp_new_vel_x;
            got.vy = rsp_new_vel_y;
            got.sing = rsp_singular;
            got.sat = rsp_saturated;
            if (!sb.check_result(got, msg)) report(msg);
         end
         if (hold_request) begin
            hold_request = 0;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_pop <= 0;
         end else if (idling_on && $urandom_range(5) == 0) begin
            gap_left = $urandom_range(10);
            rsp_pop <= 0;
         end else begin
            rsp_pop <= 1;
         end
      end
   end

   // Offer one item and hold it until the block takes it
   task automatic send_body(body_item_type it);
      req_type <= it.kind;
      req_pos_x <= it.px;
      req_pos_y <= it.py;
      req_vel_x <= it.vx;
      req_vel_y <= it.vy;
      req_push <= 1;
      do @(posedge clock); while (req_full);
      sb.note_item(it);
      if (idling_on && $urandom_range(4) == 0) begin
         req_push <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_push <= 0;
      while (sb.expected_steps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.set_reg(idx, val);
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(32'h7fffffff)) >>> $urandom_range(8));
         2: return 32'(int'($urandom_range(32'h3fffffff)) - 32'sh20000000);
         default: return 32'(int'($urandom_range(32'h1fff)) - 4096);
      endcase
   endfunction

   // Random body: mostly test bodies, some near the planet
   function automatic body_item_type pick_body();
      body_item_type it;
      int r;
      r = $urandom_range(99);
      it.kind = r < 4 ? REQ_NONE : r < 12 ? REQ_LOAD : r < 22 ? REQ_ADV : REQ_TEST;
      it.px = pick_coord();
      it.py = pick_coord();
      if (it.kind == REQ_TEST && $urandom_range(3) == 0) begin
         it.px = sb.plx[31:0] + 32'(int'($urandom_range(65535)) - 32768);
         it.py = sb.ply[31:0] + 32'(int'($urandom_range(65535)) - 32768);
      end
      if ($urandom_range(3) == 0) begin
         it.vx = $urandom;
         it.vy = $urandom;
      end else begin
         it.vx = 32'(int'($urandom_range(32'h1fffffff)) - 32'sh10000000);
         it.vy = 32'(int'($urandom_range(32'h1fffffff)) - 32'sh10000000);
      end
      return it;
   endfunction

   function automatic body_item_type mk(logic [1:0] k, logic [31:0] a, b, c, d);
      body_item_type it;
      it.kind = k; it.px = a; it.py = b; it.vx = c; it.vy = d;
      return it;
   endfunction

   task automatic run_random(int count);
      repeat (count) send_body(pick_body());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, every code, zero distances, huge pulls, overflow
      send_body(mk(REQ_ADV, 0, 0, 0, 0));
      send_body(mk(REQ_TEST, 32'h10000000, 0, 0, 32'h10000000));
      send_body(mk(REQ_TEST, 0, 0, 32'h7fffffff, 32'h80000000));
      send_body(mk(REQ_TEST, 32'h10000000, 0, 0, 0));
      send_body(mk(REQ_TEST, 1, 0, 0, 0));
      send_body(mk(REQ_TEST, 0, 32'hffffffff, 0, 0));
      send_body(mk(REQ_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
      send_body(mk(REQ_LOAD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
      send_body(mk(REQ_TEST, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
      send_body(mk(REQ_ADV, 0, 0, 0, 0));
      send_body(mk(REQ_TEST, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      send_body(mk(REQ_LOAD, 0, 0, 0, 0));
      send_body(mk(REQ_ADV, 0, 0, 0, 0));
      send_body(mk(REQ_TEST, 0, 0, 0, 0));
      send_body(mk(REQ_LOAD, 32'h10000000, 0, 0, 32'h10000000));
      send_body(mk(REQ_TEST, 32'h10000000, 1, 0, 0));
      send_body(mk(REQ_TEST, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
      send_body(mk(REQ_ADV, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
      send_body(mk(REQ_NONE, 0, 0, 0, 0));

      // Default registers; fill the block while the receiver holds off
      run_random(60);
      hold_request = 1;
      run_random(120);
      wait_idle();

      // Largest registers
      write_reg(CSR_SUN_MASS, 32'hffffffff);
      write_reg(CSR_PLANET_MASS, 32'hffffffff);
      write_reg(CSR_TIME_STEP, 32'hffffffff);
      run_random(130);
      wait_idle();

      // Zero registers
      write_reg(CSR_SUN_MASS, 0);
      write_reg(CSR_PLANET_MASS, 0);
      write_reg(CSR_TIME_STEP, 0);
      run_random(120);
      wait_idle();

      // Random masses, small step
      write_reg(CSR_SUN_MASS, $urandom);
      write_reg(CSR_PLANET_MASS, $urandom);
      write_reg(CSR_TIME_STEP, $urandom_range(32'h00ffffff));
      run_random(130);
      wait_idle();

      // Strong planet, moderate step
      write_reg(CSR_SUN_MASS, 32'h10000000);
      write_reg(CSR_PLANET_MASS, 32'h04000000);
      write_reg(CSR_TIME_STEP, 32'h00100000);
      run_random(130);
      wait_idle();

      // Back to defaults, no idling to the end
      write_reg(CSR_SUN_MASS, SUN_MASS_RST);
      write_reg(CSR_PLANET_MASS, PLANET_MASS_RST);
      write_reg(CSR_TIME_STEP, TIME_STEP_RST);
      idling_on = 0;
      run_random(240);

      wait_idle();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
